FILE: design/wall_spring_force_core_assert.svh
// Assertion macros for the wall spring force core.
`ifndef WALL_SPRING_FORCE_CORE_ASSERT_SVH
`define WALL_SPRING_FORCE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define WSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define WSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define WSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/wsf_pkg.sv
package wsf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_W      = 32;
    localparam int UREG_W      = WORD_W - 1;
    localparam int DIFF_W      = WORD_W + 1;
    localparam int SQ_W        = 2 * WORD_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 4;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int NUM_W       = 2 * FRAC_BITS + 1;
    localparam int XW          = ROOT_W;
    localparam int DIV_STAGES  = NUM_W;
    localparam int MUL_W       = ROOT_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int MAG_W       = PROD_W - FRAC_BITS;
    localparam int CFG_IDX_W   = 3;

    localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [UREG_W-1:0] ONE_Q = UREG_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K_MAIN   = 3'd0,
        CFG_K_ALT    = 3'd1,
        CFG_ADHESION = 3'd2,
        CFG_ZERO_INA = 3'd3,
        CFG_NUM_DIMS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] len;
        logic              sel;
        logic              act;
    } t_side;

    typedef struct packed {
        logic [DIFF_W-1:0] x;
        logic [DIFF_W-1:0] y;
        logic [DIFF_W-1:0] z;
    } t_diffs;

    function automatic logic [WORD_W-1:0] sat_word(input logic neg,
                                                   input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] negm;
        lim  = MAG_W'(WMAX);
        negm = -m;
        if (!neg) begin
            sat_word = (m > lim) ? WMAX : m[WORD_W-1:0];
        end else if (m > lim + MAG_W'(1)) begin
            sat_word = WMIN;
        end else begin
            sat_word = negm[WORD_W-1:0];
        end
    endfunction

endpackage

FILE: design/wsf_lane.sv
module wsf_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_use,
    input  logic [wsf_pkg::WORD_W-1:0]  i_first,
    input  logic [wsf_pkg::WORD_W-1:0]  i_second,
    output logic [wsf_pkg::DIFF_W-1:0]  o_diff,
    output logic [wsf_pkg::SQ_W-1:0]    o_sq
);
    import wsf_pkg::*;

    logic [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0] r_diff;
    logic [DIFF_W-1:0] mag;
    logic [SQ_W-1:0]   r_sq;

    assign n_diff = i_use ? ({i_first[WORD_W-1], i_first} - {i_second[WORD_W-1], i_second})
                          : '0;
    assign mag    = r_diff[DIFF_W-1] ? -r_diff : r_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
            r_sq   <= SQ_W'(mag[WORD_W-1:0]) * SQ_W'(mag[WORD_W-1:0]);
        end
    end

    assign o_diff = r_diff;
    assign o_sq   = r_sq;
endmodule

FILE: design/wsf_sqrt.sv
module wsf_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [wsf_pkg::SUM_W-1:0]   i_rad,
    output logic [wsf_pkg::ROOT_W-1:0]  o_root
);
    import wsf_pkg::*;

    logic [REM_W-1:0]  r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_root [SQRT_STAGES];
    logic [SUM_W-1:0]  r_rad  [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic [REM_W-1:0]  p_rem;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] p_root;
        logic [SUM_W-1:0]  p_rad;
        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
        end
        assign rem_sh = {p_rem[REM_W-3:0], p_rad[SUM_W-1 -: 2]};
        assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_sh >= trial) begin
                    r_rem[g]  <= rem_sh - trial;
                    r_root[g] <= {p_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= rem_sh;
                    r_root[g] <= {p_root[ROOT_W-2:0], 1'b0};
                end
                r_rad[g] <= {p_rad[SUM_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
endmodule

FILE: design/wsf_recip.sv
module wsf_recip (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_neg,
    input  logic [wsf_pkg::XW-1:0]      i_mag,
    output logic [wsf_pkg::WORD_W-1:0]  o_recip,
    output logic                        o_zero
);
    import wsf_pkg::*;

    logic [XW-1:0]    r_rem  [DIV_STAGES];
    logic [NUM_W-1:0] r_q    [DIV_STAGES];
    logic [XW-1:0]    r_x    [DIV_STAGES];
    logic             r_neg  [DIV_STAGES];
    logic             r_zero [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [XW-1:0]    p_rem;
        logic [NUM_W-1:0] p_q;
        logic [XW-1:0]    p_x;
        logic             p_neg;
        logic             p_zero;
        logic [XW:0]      rem_sh;
        logic [XW:0]      rem_sub;
        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_q    = '0;
            assign p_x    = i_mag;
            assign p_neg  = i_neg;
            assign p_zero = (i_mag == '0);
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_q    = r_q[g-1];
            assign p_x    = r_x[g-1];
            assign p_neg  = r_neg[g-1];
            assign p_zero = r_zero[g-1];
        end
        // numerator is 2^(2*FRAC_BITS): only its top bit is set
        assign rem_sh  = {p_rem, (g == 0) ? 1'b1 : 1'b0};
        assign rem_sub = rem_sh - {1'b0, p_x};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_sh >= {1'b0, p_x}) begin
                    r_rem[g] <= rem_sub[XW-1:0];
                    r_q[g]   <= {p_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[g] <= rem_sh[XW-1:0];
                    r_q[g]   <= {p_q[NUM_W-2:0], 1'b0};
                end
                r_x[g]    <= p_x;
                r_neg[g]  <= p_neg;
                r_zero[g] <= p_zero;
            end
        end
    end

    assign o_zero  = r_zero[DIV_STAGES-1];
    assign o_recip = r_zero[DIV_STAGES-1] ? WMAX
                   : sat_word(r_neg[DIV_STAGES-1], MAG_W'(r_q[DIV_STAGES-1]));
endmodule

FILE: design/wsf_mulq.sv
module wsf_mulq (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [wsf_pkg::MUL_W-1:0]   i_a,
    input  logic [wsf_pkg::MUL_W-1:0]   i_b,
    output logic [wsf_pkg::WORD_W-1:0]  o_p
);
    import wsf_pkg::*;

    logic [MUL_W-1:0]  mag_a;
    logic [MUL_W-1:0]  mag_b;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic [WORD_W-1:0] r_p;

    assign mag_a = i_a[MUL_W-1] ? -i_a : i_a;
    assign mag_b = i_b[MUL_W-1] ? -i_b : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(mag_a) * PROD_W'(mag_b);
            r_neg  <= i_a[MUL_W-1] ^ i_b[MUL_W-1];
            r_p    <= sat_word(r_neg, r_prod[PROD_W-1:FRAC_BITS]);
        end
    end

    assign o_p = r_p;
endmodule

FILE: design/wall_spring_force_core.sv
// Throughput: one wall per cycle; the whole pipeline stalls only while a
// result waits at the output register.
// The pipeline holds the 33-stage square root and the two 33-stage reciprocal dividers.
// Reset (synchronous, active low) clears valid flags and loads register defaults.
module wall_spring_force_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wsf_pkg::UREG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wsf_pkg::WORD_W-1:0]     i_first_x,
    input  logic [wsf_pkg::WORD_W-1:0]     i_first_y,
    input  logic [wsf_pkg::WORD_W-1:0]     i_first_z,
    input  logic [wsf_pkg::WORD_W-1:0]     i_second_x,
    input  logic [wsf_pkg::WORD_W-1:0]     i_second_y,
    input  logic [wsf_pkg::WORD_W-1:0]     i_second_z,
    input  logic [wsf_pkg::WORD_W-1:0]     i_rest_length,
    input  logic                           i_use_second_stiffness,
    input  logic                           i_wall_active,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [wsf_pkg::WORD_W-1:0]     o_force_x,
    output logic [wsf_pkg::WORD_W-1:0]     o_force_y,
    output logic [wsf_pkg::WORD_W-1:0]     o_force_z,
    output logic [wsf_pkg::WORD_W-1:0]     o_saved_force,
    output logic                           o_save_write,
    output logic                           o_degenerate
);
    import wsf_pkg::*;

    localparam int S_SUM   = 3;
    localparam int S_ROOT  = S_SUM + SQRT_STAGES;
    localparam int S_RECIP = S_ROOT + DIV_STAGES;
    localparam int S_DQ    = S_RECIP + 1;
    localparam int S_C1    = S_DQ + 2;
    localparam int S_C2    = S_C1 + 2;
    localparam int S_F     = S_C2 + 2;

    // configuration
    logic [UREG_W-1:0] r_k_main;
    logic [UREG_W-1:0] r_k_alt;
    logic [UREG_W-1:0] r_adh;
    logic              r_zero_ina;
    logic [1:0]        r_num_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_main   <= ONE_Q;
            r_k_alt    <= ONE_Q;
            r_adh      <= ONE_Q;
            r_zero_ina <= 1'b0;
            r_num_dims <= 2'd2;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_K_MAIN:   r_k_main   <= i_cfg_data;
                CFG_K_ALT:    r_k_alt    <= i_cfg_data;
                CFG_ADHESION: r_adh      <= i_cfg_data;
                CFG_ZERO_INA: r_zero_ina <= i_cfg_data[0];
                CFG_NUM_DIMS: r_num_dims <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // valid chain
    logic r_vld [S_F];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < S_F; i++) r_vld[i] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < S_F; i++) r_vld[i] <= r_vld[i-1];
            r_out_valid <= r_vld[S_F-1];
        end
    end

    // axis lanes
    logic [DIFF_W-1:0] diff_x, diff_y, diff_z;
    logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
    logic              use_z;
    assign use_z = (r_num_dims == 2'd3);

    wsf_lane u_lane_x (.i_clk(i_clk), .i_en(en), .i_use(1'b1), .i_first(i_first_x),
                       .i_second(i_second_x), .o_diff(diff_x), .o_sq(sq_x));
    wsf_lane u_lane_y (.i_clk(i_clk), .i_en(en), .i_use(1'b1), .i_first(i_first_y),
                       .i_second(i_second_y), .o_diff(diff_y), .o_sq(sq_y));
    wsf_lane u_lane_z (.i_clk(i_clk), .i_en(en), .i_use(use_z), .i_first(i_first_z),
                       .i_second(i_second_z), .o_diff(diff_z), .o_sq(sq_z));

    // merge lanes
    logic [SUM_W-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (en) r_sum <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    end

    // side data delay lines
    t_side  r_sd [S_F];
    t_diffs r_df [S_C2-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= '{len: i_rest_length, sel: i_use_second_stiffness,
                         act: i_wall_active};
            for (int i = 1; i < S_F; i++) r_sd[i] <= r_sd[i-1];
            r_df[0] <= '{x: diff_x, y: diff_y, z: diff_z};
            for (int i = 1; i < S_C2 - 1; i++) r_df[i] <= r_df[i-1];
        end
    end

    logic [ROOT_W-1:0] root;
    wsf_sqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_rad(r_sum), .o_root(root));

    logic [ROOT_W-1:0] r_dd [S_C2-S_ROOT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0] <= root;
            for (int i = 1; i < S_C2 - S_ROOT; i++) r_dd[i] <= r_dd[i-1];
        end
    end

    // reciprocals
    logic [WORD_W-1:0] len_in, len_mag;
    logic [WORD_W-1:0] rl, rd;
    logic              zl, zd;
    assign len_in  = r_sd[S_ROOT-1].len;
    assign len_mag = len_in[WORD_W-1] ? -len_in : len_in;

    wsf_recip u_recip_l (.i_clk(i_clk), .i_en(en), .i_neg(len_in[WORD_W-1]),
                         .i_mag(XW'(len_mag)), .o_recip(rl), .o_zero(zl));
    wsf_recip u_recip_d (.i_clk(i_clk), .i_en(en), .i_neg(1'b0),
                         .i_mag(root), .o_recip(rd), .o_zero(zd));

    // coefficient setup
    logic [WORD_W-1:0] len_r;
    logic [ROOT_W-1:0] d_r;
    logic              both;
    logic              gt;
    assign len_r = r_sd[S_RECIP-1].len;
    assign d_r   = r_dd[S_RECIP-S_ROOT-1];
    assign both  = (d_r == '0) && (len_r[WORD_W-1] || (len_r == '0));
    assign gt    = $signed({1'b0, d_r})
                 > $signed({{(ROOT_W+1-WORD_W){len_r[WORD_W-1]}}, len_r});

    logic [DIFF_W-1:0] r_dq;
    logic [UREG_W-1:0] r_k;
    logic              r_gt [S_C2-S_DQ+1];
    logic              r_dg [S_F-S_DQ+1];
    logic              n_gt, n_dg;
    assign n_gt = gt;
    assign n_dg = !both && (zl || zd);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dq <= both ? '0 : ({rl[WORD_W-1], rl} - {rd[WORD_W-1], rd});
            r_k  <= r_sd[S_RECIP-1].sel ? r_k_alt : r_k_main;
            r_gt[0] <= n_gt;
            for (int i = 1; i < S_C2 - S_DQ + 1; i++) r_gt[i] <= r_gt[i-1];
            r_dg[0] <= n_dg;
            for (int i = 1; i < S_F - S_DQ + 1; i++) r_dg[i] <= r_dg[i-1];
        end
    end

    logic [WORD_W-1:0] c1, c2, coeff;
    logic [WORD_W-1:0] r_c1d [2];

    wsf_mulq u_mul_k (.i_clk(i_clk), .i_en(en), .i_a(MUL_W'(r_k)),
                      .i_b({{(MUL_W-DIFF_W){r_dq[DIFF_W-1]}}, r_dq}), .o_p(c1));
    wsf_mulq u_mul_adh (.i_clk(i_clk), .i_en(en),
                        .i_a({{(MUL_W-WORD_W){c1[WORD_W-1]}}, c1}),
                        .i_b(MUL_W'(r_adh)), .o_p(c2));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1d[0] <= c1;
            r_c1d[1] <= r_c1d[0];
        end
    end

    assign coeff = r_gt[S_C2-S_DQ] ? c2 : r_c1d[1];

    // force lanes and saved force
    t_diffs            dfc;
    logic [MUL_W-1:0]  coeff_w;
    logic [WORD_W-1:0] fx, fy, fz, sv;
    assign dfc     = r_df[S_C2-2];
    assign coeff_w = {{(MUL_W-WORD_W){coeff[WORD_W-1]}}, coeff};

    wsf_mulq u_mul_fx (.i_clk(i_clk), .i_en(en),
                       .i_a({{(MUL_W-DIFF_W){dfc.x[DIFF_W-1]}}, dfc.x}),
                       .i_b(coeff_w), .o_p(fx));
    wsf_mulq u_mul_fy (.i_clk(i_clk), .i_en(en),
                       .i_a({{(MUL_W-DIFF_W){dfc.y[DIFF_W-1]}}, dfc.y}),
                       .i_b(coeff_w), .o_p(fy));
    wsf_mulq u_mul_fz (.i_clk(i_clk), .i_en(en),
                       .i_a({{(MUL_W-DIFF_W){dfc.z[DIFF_W-1]}}, dfc.z}),
                       .i_b(coeff_w), .o_p(fz));
    wsf_mulq u_mul_sv (.i_clk(i_clk), .i_en(en), .i_a(coeff_w),
                       .i_b(MUL_W'(r_dd[S_C2-S_ROOT-1])), .o_p(sv));

    // output register
    logic              act;
    logic [WORD_W-1:0] r_fx, r_fy, r_fz, r_sv;
    logic              r_save, r_degen;
    assign act = r_sd[S_F-1].act;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx    <= act ? fx : '0;
            r_fy    <= act ? fy : '0;
            r_fz    <= act ? fz : '0;
            r_sv    <= act ? sv : '0;
            r_save  <= act ? 1'b1 : r_zero_ina;
            r_degen <= act && r_dg[S_F-S_DQ];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_force_x     = r_fx;
    assign o_force_y     = r_fy;
    assign o_force_z     = r_fz;
    assign o_saved_force = r_sv;
    assign o_save_write  = r_save;
    assign o_degenerate  = r_degen;

`include "wall_spring_force_core_assert.svh"

    `WSF_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_in_ready)
    `WSF_ASSERT_IMP(a_no_save_zero, i_clk, i_rst_n, r_out_valid && !r_save, (r_fx == '0) && (r_sv == '0) && !r_degen)
    `WSF_ASSERT_IMP(a_degen_active, i_clk, i_rst_n, r_out_valid && r_degen, r_save)
    `WSF_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, en && r_vld[S_F-1], r_out_valid)
endmodule
